/* rtl/core/pnf_pkg.sv */
`timescale 1ns / 1ps
package pnf_pkg;

    localparam int COORD_W = 24;
    localparam int NOISE_W = 18;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    localparam logic [0:0] CFG_OCTAVES = 1'd0;
    localparam logic [0:0] CFG_UNIT    = 1'd1;

    typedef struct packed {
        logic                 is_eval;
        logic [7:0]           tidx;
        logic [7:0]           tval;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [COORD_W-1:0]   cz;
    } item_t;

endpackage

/* rtl/core/pnf_ram.sv */
`timescale 1ns / 1ps
module pnf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/pnf_front.sv */
`timescale 1ns / 1ps
module pnf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  pnf_pkg::item_t in_item,
    output logic          q_valid,
    input  logic          q_take,
    output pnf_pkg::item_t q_item
);

    // Two-entry queue between the input port and the evaluation engine.
    pnf_pkg::item_t buf_reg [2];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ q_take;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_item;
        end
    end

endmodule

/* rtl/core/pnf_back.sv */
`timescale 1ns / 1ps
module pnf_back #(
    parameter int FRAC_BITS   = 16,
    parameter int MAX_OCTAVES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_take,
    input  pnf_pkg::item_t                q_item,
    input  logic [4:0]                    octaves,
    input  logic                          unit_mode,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [pnf_pkg::NOISE_W-1:0] out_value
);

    localparam int F  = FRAC_BITS;
    localparam int CW = 8 + F;
    localparam int VW = F + 6;
    localparam int PW = 2 * VW + 2;
    localparam int SW = ((F > 16) ? F : 16) + 8;
    localparam int NW = pnf_pkg::NOISE_W;
    localparam logic signed [SW-1:0] SAT_HI = SW'(131071);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(131072);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_OCT   = 9'b000000010,
        S_HASH  = 9'b000000100,
        S_FADE  = 9'b000001000,
        S_GRAD  = 9'b000010000,
        S_LERP  = 9'b000100000,
        S_ACC   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [4:0]    oct_reg, nact_reg;
    logic [4:0]    step_reg;
    logic [7:0]    hv_reg [6];
    logic [7:0]    corner_reg [8];
    logic signed [VW-1:0] fd_reg [3];
    logic signed [VW-1:0] gr_reg [8];
    logic signed [VW-1:0] lr_reg [4];
    logic signed [SW-1:0] sum_reg;
    logic signed [NW-1:0] res_reg;
    logic                 ov_reg;

    logic       ram_we;
    logic [7:0] ram_wa, ram_wd, ram_ra, ram_rd;

    logic [7:0] xi, yi, zi;
    logic signed [VW-1:0] fx, fy, fz;
    assign xi = cx_reg[CW-1:F];
    assign yi = cy_reg[CW-1:F];
    assign zi = cz_reg[CW-1:F];
    assign fx = VW'(cx_reg[F-1:0]);
    assign fy = VW'(cy_reg[F-1:0]);
    assign fz = VW'(cz_reg[F-1:0]);

    pnf_ram #(.WIDTH(8), .DEPTH(256)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_wa),
        .wdata (ram_wd),
        .raddr (ram_ra),
        .rdata (ram_rd)
    );

    function automatic logic signed [VW-1:0] fmul(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b
    );
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        begin
            p = PW'(a) * PW'(b);
            q = (p < 0) ? -((-p) >>> F) : (p >>> F);
            return VW'(q);
        end
    endfunction

    function automatic logic signed [VW-1:0] grad(
        input logic [7:0]           hs,
        input logic signed [VW-1:0] x,
        input logic signed [VW-1:0] y,
        input logic signed [VW-1:0] z
    );
        logic [3:0]           h;
        logic signed [VW-1:0] u;
        logic signed [VW-1:0] v;
        begin
            h = hs[3:0];
            u = (h < 4'd8) ? x : y;
            v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
            return (h[0] ? -u : u) + (h[1] ? -v : v);
        end
    endfunction

    // Read schedule: step 0..1 first level, 2..5 second level, 6..13 corners.
    always_comb
    begin
        ram_ra = 8'd0;
        case (step_reg)
            5'd0:    ram_ra = xi;
            5'd1:    ram_ra = xi + 8'd1;
            5'd2:    ram_ra = hv_reg[0];
            5'd3:    ram_ra = hv_reg[0] + 8'd1;
            5'd4:    ram_ra = hv_reg[1];
            5'd5:    ram_ra = hv_reg[1] + 8'd1;
            5'd6:    ram_ra = hv_reg[2];
            5'd7:    ram_ra = hv_reg[4];
            5'd8:    ram_ra = hv_reg[3];
            5'd9:    ram_ra = hv_reg[5];
            5'd10:   ram_ra = hv_reg[2] + 8'd1;
            5'd11:   ram_ra = hv_reg[4] + 8'd1;
            5'd12:   ram_ra = hv_reg[3] + 8'd1;
            5'd13:   ram_ra = hv_reg[5] + 8'd1;
            default: ram_ra = 8'd0;
        endcase
    end

    assign ram_we = (state_reg == S_IDLE) && q_valid && !q_item.is_eval;
    assign ram_wa = q_item.tidx;
    assign ram_wd = q_item.tval;
    assign q_take = (state_reg == S_IDLE) && q_valid;

    assign out_valid = ov_reg;
    assign out_value = res_reg;

    logic signed [VW-1:0] one_v;
    logic signed [VW-1:0] fade_t, fade_in, fade_sq;
    assign one_v = VW'(1) <<< F;

    // Fade over three steps per axis: t*t, (t*t)*t, inner, cube*inner.
    logic signed [VW-1:0] fa_reg, fb_reg;
    always_comb
    begin
        case (step_reg)
            5'd0:    fade_t = fx;
            5'd3:    fade_t = fy;
            default: fade_t = fz;
        endcase
        fade_in = fmul(fade_t, fade_t * VW'(6) - VW'(15) * one_v) + VW'(10) * one_v;
        fade_sq = fmul(fade_t, fade_t);
    end

    logic signed [VW-1:0] lerp_t, lerp_a, lerp_b, lerp_r;
    always_comb
    begin
        lerp_t = fd_reg[0];
        lerp_a = gr_reg[0];
        lerp_b = gr_reg[1];
        case (step_reg[2:0])
            3'd1:
            begin
                lerp_a = gr_reg[2];
                lerp_b = gr_reg[3];
            end
            3'd2:
            begin
                lerp_a = gr_reg[4];
                lerp_b = gr_reg[5];
            end
            3'd3:
            begin
                lerp_a = gr_reg[6];
                lerp_b = gr_reg[7];
            end
            3'd4:
            begin
                lerp_t = fd_reg[1];
                lerp_a = lr_reg[0];
                lerp_b = lr_reg[1];
            end
            3'd5:
            begin
                lerp_t = fd_reg[1];
                lerp_a = lr_reg[2];
                lerp_b = lr_reg[3];
            end
            3'd6, 3'd7:
            begin
                lerp_t = fd_reg[2];
                lerp_a = lr_reg[0];
                lerp_b = lr_reg[1];
            end
            default: ;
        endcase
        lerp_r = lerp_a + fmul(lerp_t, lerp_b - lerp_a);
    end

    logic signed [SW-1:0] term, ext_n, half_s, fin_s, sh_s;
    always_comb
    begin
        ext_n = SW'(lr_reg[0]);
        term  = (ext_n < 0) ? -((-ext_n) >>> oct_reg) : (ext_n >>> oct_reg);
        half_s = (sum_reg < 0) ? -((-sum_reg) >>> 1) : (sum_reg >>> 1);
        fin_s  = unit_mode ? half_s + (SW'(1) <<< (F - 1)) : sum_reg;
        if (F > 16)
        begin
            sh_s = (fin_s < 0) ? -((-fin_s) >>> (F - 16)) : (fin_s >>> (F - 16));
        end
        else
        begin
            sh_s = fin_s <<< (16 - F);
        end
    end

    logic signed [SW+8-1:0] sh_w;
    always_comb
    begin
        sh_w = (SW+8)'(sh_s);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid && q_item.is_eval) state_next = S_OCT;
            S_OCT:  state_next = (oct_reg >= nact_reg) ? S_FIN : S_HASH;
            S_HASH: if (step_reg == 5'd14) state_next = S_FADE;
            S_FADE: if (step_reg == 5'd8) state_next = S_GRAD;
            S_GRAD: state_next = S_LERP;
            S_LERP: if (step_reg == 5'd6) state_next = S_ACC;
            S_ACC:  state_next = S_OCT;
            S_FIN:  state_next = S_OUT;
            S_OUT:  if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            step_reg  <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= (state_next == S_OUT);
            if (state_next != state_reg)
            begin
                step_reg <= 5'd0;
            end
            else
            begin
                step_reg <= step_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cx_reg   <= CW'(q_item.cx);
                cy_reg   <= CW'(q_item.cy);
                cz_reg   <= CW'(q_item.cz);
                oct_reg  <= 5'd0;
                sum_reg  <= '0;
                nact_reg <= (octaves > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : octaves;
            end
            S_HASH:
            begin
                // Data read at step s-1 arrives at step s.
                case (step_reg)
                    5'd1:  hv_reg[0] <= ram_rd + yi;
                    5'd2:  hv_reg[1] <= ram_rd + yi;
                    5'd3:  hv_reg[2] <= ram_rd + zi;
                    5'd4:  hv_reg[3] <= ram_rd + zi;
                    5'd5:  hv_reg[4] <= ram_rd + zi;
                    5'd6:  hv_reg[5] <= ram_rd + zi;
                    5'd7:  corner_reg[0] <= ram_rd;
                    5'd8:  corner_reg[1] <= ram_rd;
                    5'd9:  corner_reg[2] <= ram_rd;
                    5'd10: corner_reg[3] <= ram_rd;
                    5'd11: corner_reg[4] <= ram_rd;
                    5'd12: corner_reg[5] <= ram_rd;
                    5'd13: corner_reg[6] <= ram_rd;
                    5'd14: corner_reg[7] <= ram_rd;
                    default: ;
                endcase
            end
            S_FADE:
            begin
                // Per axis: step 3a -> fa=t*t, fb=inner; 3a+1 -> fa=fa*t; 3a+2 -> fa*fb.
                case (step_reg)
                    5'd0, 5'd3, 5'd6:
                    begin
                        fa_reg <= fade_sq;
                        fb_reg <= fade_in;
                    end
                    5'd1, 5'd4, 5'd7:
                        fa_reg <= fmul(fa_reg, (step_reg == 5'd1) ? fx :
                                              ((step_reg == 5'd4) ? fy : fz));
                    5'd2: fd_reg[0] <= fmul(fa_reg, fb_reg);
                    5'd5: fd_reg[1] <= fmul(fa_reg, fb_reg);
                    5'd8: fd_reg[2] <= fmul(fa_reg, fb_reg);
                    default: ;
                endcase
            end
            S_GRAD:
            begin
                gr_reg[0] <= grad(corner_reg[0], fx, fy, fz);
                gr_reg[1] <= grad(corner_reg[1], fx - one_v, fy, fz);
                gr_reg[2] <= grad(corner_reg[2], fx, fy - one_v, fz);
                gr_reg[3] <= grad(corner_reg[3], fx - one_v, fy - one_v, fz);
                gr_reg[4] <= grad(corner_reg[4], fx, fy, fz - one_v);
                gr_reg[5] <= grad(corner_reg[5], fx - one_v, fy, fz - one_v);
                gr_reg[6] <= grad(corner_reg[6], fx, fy - one_v, fz - one_v);
                gr_reg[7] <= grad(corner_reg[7], fx - one_v, fy - one_v, fz - one_v);
            end
            S_LERP:
            begin
                case (step_reg[2:0])
                    3'd0: lr_reg[0] <= lerp_r;
                    3'd1: lr_reg[1] <= lerp_r;
                    3'd2: lr_reg[2] <= lerp_r;
                    3'd3: lr_reg[3] <= lerp_r;
                    3'd4: lr_reg[0] <= lerp_r;
                    3'd5: lr_reg[1] <= lerp_r;
                    3'd6: lr_reg[0] <= lerp_r;
                    default: ;
                endcase
            end
            S_ACC:
            begin
                sum_reg <= sum_reg + term;
                oct_reg <= oct_reg + 5'd1;
                cx_reg  <= {cx_reg[CW-2:0], 1'b0};
                cy_reg  <= {cy_reg[CW-2:0], 1'b0};
                cz_reg  <= {cz_reg[CW-2:0], 1'b0};
            end
            S_FIN:
            begin
                if (sh_w > (SW+8)'(SAT_HI))
                begin
                    res_reg <= NW'(131071);
                end
                else if (sh_w < (SW+8)'(SAT_LO))
                begin
                    res_reg <= NW'(-131072);
                end
                else
                begin
                    res_reg <= NW'(sh_w);
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/perlin_noise_3d_fractal_core.sv */
`timescale 1ns / 1ps
// Channel | Signals                                             | Dir
// input   | in_valid, in_stall, op, table_index, table_value, coord_* | in
// output  | out_valid, out_stall, noise_value                   | out
// config  | cfg_we, cfg_index, cfg_data                         | in
// A table write is taken by the idle engine; an evaluation holds the engine for
// each octave through the hash reads on the single table read port, then fade,
// gradient, lerp and accumulate, and longer while out_stall holds the result.
// Reset clears the control state; the permutation table is undefined until written.
// A two-word queue keeps accepting input until it fills while a result waits on out_stall.
module perlin_noise_3d_fractal_core #(
    parameter int FRAC_BITS   = 16,
    parameter int MAX_OCTAVES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [7:0]                         table_index,
    input  logic [7:0]                         table_value,
    input  logic [pnf_pkg::COORD_W-1:0]        coord_x,
    input  logic [pnf_pkg::COORD_W-1:0]        coord_y,
    input  logic [pnf_pkg::COORD_W-1:0]        coord_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pnf_pkg::NOISE_W-1:0] noise_value,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [4:0]                         cfg_data
);

    logic [4:0]     oct_reg;
    logic           unit_reg;
    pnf_pkg::item_t in_item, q_item;
    logic           q_valid, q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg  <= 5'd1;
            unit_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pnf_pkg::CFG_OCTAVES: oct_reg  <= cfg_data;
                pnf_pkg::CFG_UNIT:    unit_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_item.is_eval = (op == pnf_pkg::OP_EVAL);
        in_item.tidx    = table_index;
        in_item.tval    = table_value;
        in_item.cx      = coord_x;
        in_item.cy      = coord_y;
        in_item.cz      = coord_z;
    end

    pnf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item)
    );

    pnf_back #(.FRAC_BITS(FRAC_BITS), .MAX_OCTAVES(MAX_OCTAVES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_item    (q_item),
        .octaves   (oct_reg),
        .unit_mode (unit_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (noise_value)
    );

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(noise_value))
        else $error("result changed while stalled");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid)
        else $error("queue read while empty");
    a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_valid)
        else $error("stall while queue empty");
`endif

endmodule
